FILE: rtl/psc_pkg.sv
// Package with the shared constants, codes and types of the port session classifier.
package psc_pkg;

  localparam int SESSION_CAPACITY = 64;

  localparam int PORT_W = 16;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  localparam logic [15:0] WEB_PORT_RESET   = 16'd80;
  localparam logic [15:0] SHELL_PORT_RESET = 16'd22;
  localparam logic [15:0] NAME_PORT_RESET  = 16'd53;

  typedef enum logic [2:0] {
    CLS_NONE  = 3'd0,
    CLS_ICMP  = 3'd1,
    CLS_WEB   = 3'd2,
    CLS_SHELL = 3'd3,
    CLS_NAME  = 3'd4
  } class_t;

  typedef enum logic [1:0] {
    SVC_WEB   = 2'd0,
    SVC_SHELL = 2'd1,
    SVC_NAME  = 2'd2
  } svc_t;

  typedef enum logic [1:0] {
    REG_WEB_PORT   = 2'd0,
    REG_SHELL_PORT = 2'd1,
    REG_NAME_PORT  = 2'd2
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_DONE   = 2'd2
  } state_t;

  typedef struct packed {
    logic              active;
    logic              hit;
    svc_t              tbl;
    logic [PORT_W-1:0] port;
  } tok_t;

endpackage

FILE: rtl/psc_cell.sv
// One cell of the session chain: holds one slot of each service table and passes the search on.
module psc_cell #(
  parameter int CNT_W = 7
) (
  input  logic           clk,
  input  logic           rst,
  input  psc_pkg::tok_t  tok_in,
  input  logic [CNT_W-1:0] pos_in,
  input  logic [CNT_W-1:0] cnt_in,
  input  logic [CNT_W-1:0] hidx_in,
  output psc_pkg::tok_t  tok_out,
  output logic [CNT_W-1:0] pos_out,
  output logic [CNT_W-1:0] cnt_out,
  output logic [CNT_W-1:0] hidx_out
);

  logic [psc_pkg::PORT_W-1:0] web_ent;
  logic [psc_pkg::PORT_W-1:0] shell_ent;
  logic [psc_pkg::PORT_W-1:0] name_ent;
  logic [psc_pkg::PORT_W-1:0] cur_ent;
  logic                       match;
  logic                       wr;

  always_comb begin
    case (tok_in.tbl)
      psc_pkg::SVC_WEB:   cur_ent = web_ent;
      psc_pkg::SVC_SHELL: cur_ent = shell_ent;
      psc_pkg::SVC_NAME:  cur_ent = name_ent;
      default:            cur_ent = web_ent;
    endcase
  end

  assign match = tok_in.active && !tok_in.hit && (pos_in < cnt_in) && (cur_ent == tok_in.port);
  assign wr    = tok_in.active && !tok_in.hit && (pos_in == cnt_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out.active <= tok_in.active;
    end
    tok_out.hit  <= tok_in.hit | match;
    tok_out.tbl  <= tok_in.tbl;
    tok_out.port <= tok_in.port;
    pos_out      <= pos_in + CNT_W'(1);
    cnt_out      <= cnt_in;
    hidx_out     <= match ? (pos_in + CNT_W'(1)) : hidx_in;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      case (tok_in.tbl)
        psc_pkg::SVC_WEB:   web_ent   <= tok_in.port;
        psc_pkg::SVC_SHELL: shell_ent <= tok_in.port;
        psc_pkg::SVC_NAME:  name_ent  <= tok_in.port;
        default:            web_ent   <= web_ent;
      endcase
    end
  end

endmodule

FILE: rtl/port_session_classifier_top.sv
// Top level of the port session classifier: header decode, session cell chain and result register.
// Packets that need no session lookup pass from the input transfer through the result register to
// the output; web, shell and name service packets first walk the session cell chain.
// The lookup walks the chain of SESSION_CAPACITY cells, one cell per cycle, one packet at a time.
// Reset clears the counts, the chain and the handshake state, and loads the default service ports.
module port_session_classifier_top #(
  parameter int SESSION_CAPACITY = psc_pkg::SESSION_CAPACITY,
  parameter int CNT_W            = $clog2(SESSION_CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [15:0]      ether_type,
  input  logic [7:0]       ip_protocol,
  input  logic [3:0]       ip_header_words,
  input  logic [15:0]      ip_total_length,
  input  logic [3:0]       tcp_header_words,
  input  logic [15:0]      udp_length,
  input  logic [15:0]      src_port,
  input  logic [15:0]      dst_port,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       traffic_class,
  output logic [CNT_W-1:0] session_index,
  output logic [15:0]      payload_length,
  output logic             length_error
);

  localparam logic [CNT_W-1:0] CAP = CNT_W'(SESSION_CAPACITY);

  psc_pkg::state_t state, state_next;

  logic [15:0] web_port;
  logic [15:0] shell_port;
  logic [15:0] name_port;

  logic [CNT_W-1:0] web_cnt;
  logic [CNT_W-1:0] shell_cnt;
  logic [CNT_W-1:0] name_cnt;

  psc_pkg::tok_t    tok  [0:SESSION_CAPACITY];
  logic [CNT_W-1:0] pos  [0:SESSION_CAPACITY];
  logic [CNT_W-1:0] cnt  [0:SESSION_CAPACITY];
  logic [CNT_W-1:0] hidx [0:SESSION_CAPACITY];
  logic [SESSION_CAPACITY-1:0] act;

  logic             in_xfer;
  logic             load_out;
  logic             is_ip;
  logic             web_hit;
  logic             shell_hit;
  logic             name_hit;
  logic [6:0]       tcp_sub;
  logic             tcp_neg;
  logic [15:0]      tcp_len;
  logic             udp_neg;
  logic [15:0]      udp_len;
  psc_pkg::class_t  cls_in;
  psc_pkg::svc_t    svc_in;
  logic [15:0]      client_in;
  logic             search_in;
  logic [15:0]      pay_in;
  logic             err_in;
  logic [CNT_W-1:0] cnt_sel;
  logic [CNT_W-1:0] fin_cnt;
  logic             search_end;

  psc_pkg::class_t  res_cls;
  logic [CNT_W-1:0] res_idx;
  logic [15:0]      res_pay;
  logic             res_err;

  assign in_xfer  = in_valid && in_ready;
  assign load_out = (state == psc_pkg::ST_DONE) && (!out_valid || out_ready);

  assign is_ip     = (ether_type == psc_pkg::ETHERTYPE_IPV4);
  assign web_hit   = (src_port == web_port) || (dst_port == web_port);
  assign shell_hit = (src_port == shell_port) || (dst_port == shell_port);
  assign name_hit  = (src_port == name_port) || (dst_port == name_port);
  assign tcp_sub   = {1'b0, ip_header_words, 2'b00} + {1'b0, tcp_header_words, 2'b00};
  assign tcp_neg   = ip_total_length < {9'd0, tcp_sub};
  assign tcp_len   = ip_total_length - {9'd0, tcp_sub};
  assign udp_neg   = udp_length < psc_pkg::UDP_HDR_BYTES;
  assign udp_len   = udp_length - psc_pkg::UDP_HDR_BYTES;

  always_comb begin
    cls_in    = psc_pkg::CLS_NONE;
    svc_in    = psc_pkg::SVC_WEB;
    client_in = src_port;
    search_in = 1'b0;
    pay_in    = 16'd0;
    err_in    = 1'b0;
    if (is_ip) begin
      if (ip_protocol == psc_pkg::PROTO_ICMP) begin
        cls_in = psc_pkg::CLS_ICMP;
        pay_in = ip_total_length;
      end else if (ip_protocol == psc_pkg::PROTO_TCP) begin
        if (web_hit) begin
          cls_in    = psc_pkg::CLS_WEB;
          svc_in    = psc_pkg::SVC_WEB;
          client_in = (src_port == web_port) ? dst_port : src_port;
          search_in = 1'b1;
          pay_in    = tcp_neg ? 16'd0 : tcp_len;
          err_in    = tcp_neg;
        end else if (shell_hit) begin
          cls_in    = psc_pkg::CLS_SHELL;
          svc_in    = psc_pkg::SVC_SHELL;
          client_in = (src_port == shell_port) ? dst_port : src_port;
          search_in = 1'b1;
          pay_in    = tcp_neg ? 16'd0 : tcp_len;
          err_in    = tcp_neg;
        end
      end else if (ip_protocol == psc_pkg::PROTO_UDP) begin
        if (name_hit) begin
          cls_in    = psc_pkg::CLS_NAME;
          svc_in    = psc_pkg::SVC_NAME;
          client_in = (src_port == name_port) ? dst_port : src_port;
          search_in = 1'b1;
          pay_in    = udp_neg ? 16'd0 : udp_len;
          err_in    = udp_neg;
        end
      end
    end
  end

  always_comb begin
    case (svc_in)
      psc_pkg::SVC_WEB:   cnt_sel = web_cnt;
      psc_pkg::SVC_SHELL: cnt_sel = shell_cnt;
      psc_pkg::SVC_NAME:  cnt_sel = name_cnt;
      default:            cnt_sel = web_cnt;
    endcase
  end

  assign tok[0].active = in_xfer && search_in;
  assign tok[0].hit    = 1'b0;
  assign tok[0].tbl    = svc_in;
  assign tok[0].port   = client_in;
  assign pos[0]        = '0;
  assign cnt[0]        = cnt_sel;
  assign hidx[0]       = '0;

  for (genvar i = 0; i < SESSION_CAPACITY; i++) begin : g_cell
    psc_cell #(
      .CNT_W(CNT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[i]),
      .pos_in  (pos[i]),
      .cnt_in  (cnt[i]),
      .hidx_in (hidx[i]),
      .tok_out (tok[i+1]),
      .pos_out (pos[i+1]),
      .cnt_out (cnt[i+1]),
      .hidx_out(hidx[i+1])
    );
    assign act[i] = tok[i+1].active;
  end

  assign search_end = (state == psc_pkg::ST_SEARCH) && tok[SESSION_CAPACITY].active;
  assign fin_cnt    = cnt[SESSION_CAPACITY];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      psc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = search_in ? psc_pkg::ST_SEARCH : psc_pkg::ST_DONE;
        end
      end
      psc_pkg::ST_SEARCH: begin
        if (tok[SESSION_CAPACITY].active) begin
          state_next = psc_pkg::ST_DONE;
        end
      end
      psc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = psc_pkg::ST_IDLE;
        end
      end
      default: state_next = psc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      web_port   <= psc_pkg::WEB_PORT_RESET;
      shell_port <= psc_pkg::SHELL_PORT_RESET;
      name_port  <= psc_pkg::NAME_PORT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        psc_pkg::REG_WEB_PORT:   web_port   <= cfg_data;
        psc_pkg::REG_SHELL_PORT: shell_port <= cfg_data;
        psc_pkg::REG_NAME_PORT:  name_port  <= cfg_data;
        default:                 web_port   <= web_port;
      endcase
    end
  end

  // A miss appends the client port, so the table grows by one unless it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      web_cnt   <= '0;
      shell_cnt <= '0;
      name_cnt  <= '0;
    end else if (search_end && !tok[SESSION_CAPACITY].hit && (fin_cnt < CAP)) begin
      case (tok[SESSION_CAPACITY].tbl)
        psc_pkg::SVC_WEB:   web_cnt   <= fin_cnt + CNT_W'(1);
        psc_pkg::SVC_SHELL: shell_cnt <= fin_cnt + CNT_W'(1);
        psc_pkg::SVC_NAME:  name_cnt  <= fin_cnt + CNT_W'(1);
        default:            web_cnt   <= web_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_cls <= cls_in;
      res_idx <= '0;
      res_pay <= pay_in;
      res_err <= err_in;
    end else if (search_end) begin
      if (tok[SESSION_CAPACITY].hit) begin
        res_idx <= hidx[SESSION_CAPACITY];
      end else if (fin_cnt < CAP) begin
        res_idx <= fin_cnt + CNT_W'(1);
      end else begin
        res_idx <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      traffic_class  <= res_cls;
      session_index  <= res_idx;
      payload_length <= res_pay;
      length_error   <= res_err;
    end
  end

  a_one_search: assert property (@(posedge clk) disable iff (rst) $onehot0(act))
    else $error("more than one search in the cell chain");

  a_chain_idle: assert property (@(posedge clk) disable iff (rst)
    tok[SESSION_CAPACITY].active |-> state == psc_pkg::ST_SEARCH)
    else $error("search left the chain outside a lookup");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (web_cnt <= CAP) && (shell_cnt <= CAP) && (name_cnt <= CAP))
    else $error("session count beyond capacity");

  a_idx_class: assert property (@(posedge clk) disable iff (rst)
    (out_valid && session_index != '0) |->
      (traffic_class == psc_pkg::CLS_WEB || traffic_class == psc_pkg::CLS_SHELL ||
       traffic_class == psc_pkg::CLS_NAME))
    else $error("session index on a packet without a service table");

endmodule
